[hw/rtl/msb_pkg.sv]
// Shared types and constants for the merge sort buffer.
// No dependencies; imported by msb_merge and merge_sort_buffer_top.
package msb_pkg;

    localparam int DATA_W = 32;

    typedef logic [DATA_W-1:0] data_t;

    // Status from the merge sequencer to the top-level controller
    typedef struct packed {
        logic done;      // one-cycle pulse: sorted list is in place
        logic src_in_b;  // store B holds the current source / sorted list
    } sort_status_t;

endpackage

[hw/rtl/msb_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module msb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/msb_merge.sv]
// Bottom-up merge sequencer: runs doubling-width passes between two stores.
// Depends on msb_pkg; drives the shared read port and the destination write port.
module msb_merge
    import msb_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [$clog2(MAX_ELEMENTS+1)-1:0]   count,
    input  data_t                               rd_data,
    output logic [$clog2(MAX_ELEMENTS)-1:0]     rd_addr,
    output logic                                wr_en,
    output logic [$clog2(MAX_ELEMENTS)-1:0]     wr_addr,
    output data_t                               wr_data,
    output sort_status_t                        status
);

    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int SW = CW + 2;

    typedef enum logic [1:0] {
        M_IDLE,
        M_SETUP,
        M_FETCH_R,
        M_MERGE
    } merge_state_t;

    merge_state_t  state_reg;
    logic [CW:0]   width_reg;
    logic [CW-1:0] lo_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] j_reg;
    logic [CW-1:0] k_reg;
    logic [CW-1:0] mid_reg;
    logic [CW-1:0] hi_reg;
    data_t         head_l_reg;
    data_t         head_r_reg;
    logic          fresh_l_reg;
    logic          fresh_r_reg;
    logic          src_b_reg;
    logic          done_reg;

    logic [SW-1:0] mid_sum;
    logic [SW-1:0] hi_sum;
    logic [SW-1:0] n_ext;
    logic [CW-1:0] mid_clip;
    logic [CW-1:0] hi_clip;
    logic [CW:0]   width_dbl;
    logic [CW-1:0] i_inc;
    logic [CW-1:0] j_inc;
    logic [CW-1:0] k_inc;
    data_t         cur_l;
    data_t         cur_r;
    logic          l_ok;
    logic          r_ok;
    logic          take_l;
    logic          pair_last;
    logic          pass_last;
    logic          sort_last;

    // Run bounds for the pair that starts at lo_reg, clipped to the list length
    assign n_ext    = SW'(count);
    assign mid_sum  = SW'(lo_reg) + SW'(width_reg);
    assign hi_sum   = SW'(lo_reg) + SW'({width_reg, 1'b0});
    assign mid_clip = (mid_sum > n_ext) ? count : mid_sum[CW-1:0];
    assign hi_clip  = (hi_sum > n_ext) ? count : hi_sum[CW-1:0];

    assign width_dbl = {width_reg[CW-1:0], 1'b0};
    assign i_inc     = i_reg + 1'b1;
    assign j_inc     = j_reg + 1'b1;
    assign k_inc     = k_reg + 1'b1;

    // The side consumed last cycle has its new head arriving from the RAM
    assign cur_l  = fresh_l_reg ? rd_data : head_l_reg;
    assign cur_r  = fresh_r_reg ? rd_data : head_r_reg;
    assign l_ok   = i_reg < mid_reg;
    assign r_ok   = j_reg < hi_reg;
    // Strictly less takes left; a tie takes the right run's element
    assign take_l = l_ok && (!r_ok || ($signed(cur_l) < $signed(cur_r)));

    assign pair_last = k_inc == hi_reg;
    assign pass_last = hi_reg == count;
    assign sort_last = width_dbl >= (CW + 1)'(count);

    always_comb
    begin
        unique case (state_reg)
            M_SETUP:   rd_addr = lo_reg[AW-1:0];
            M_FETCH_R: rd_addr = j_reg[AW-1:0];
            M_MERGE:   rd_addr = take_l ? i_inc[AW-1:0] : j_inc[AW-1:0];
            default:   rd_addr = lo_reg[AW-1:0];
        endcase
    end

    assign wr_en   = state_reg == M_MERGE;
    assign wr_addr = k_reg[AW-1:0];
    assign wr_data = take_l ? cur_l : cur_r;

    assign status.done     = done_reg;
    assign status.src_in_b = src_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= M_IDLE;
            width_reg   <= '0;
            lo_reg      <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            mid_reg     <= '0;
            hi_reg      <= '0;
            fresh_l_reg <= 1'b0;
            fresh_r_reg <= 1'b0;
            src_b_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        width_reg <= (CW + 1)'(1);
                        lo_reg    <= '0;
                        src_b_reg <= 1'b0;
                        if (count <= CW'(1))
                        begin
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= M_SETUP;
                        end
                    end
                end
                M_SETUP:
                begin
                    // Left head read is in flight
                    i_reg     <= lo_reg;
                    j_reg     <= mid_clip;
                    k_reg     <= lo_reg;
                    mid_reg   <= mid_clip;
                    hi_reg    <= hi_clip;
                    state_reg <= M_FETCH_R;
                end
                M_FETCH_R:
                begin
                    head_l_reg  <= rd_data;
                    fresh_l_reg <= 1'b0;
                    fresh_r_reg <= 1'b1;
                    state_reg   <= M_MERGE;
                end
                M_MERGE:
                begin
                    k_reg <= k_inc;
                    if (take_l)
                    begin
                        i_reg       <= i_inc;
                        head_r_reg  <= cur_r;
                        fresh_l_reg <= 1'b1;
                        fresh_r_reg <= 1'b0;
                    end
                    else
                    begin
                        j_reg       <= j_inc;
                        head_l_reg  <= cur_l;
                        fresh_l_reg <= 1'b0;
                        fresh_r_reg <= 1'b1;
                    end
                    if (pair_last)
                    begin
                        if (pass_last)
                        begin
                            src_b_reg <= !src_b_reg;
                            width_reg <= width_dbl;
                            lo_reg    <= '0;
                            if (sort_last)
                            begin
                                done_reg  <= 1'b1;
                                state_reg <= M_IDLE;
                            end
                            else
                            begin
                                state_reg <= M_SETUP;
                            end
                        end
                        else
                        begin
                            lo_reg    <= hi_reg;
                            state_reg <= M_SETUP;
                        end
                    end
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

endmodule

[hw/rtl/merge_sort_buffer_top.sv]
// Top level of the merge sort buffer: load, sort and emit control, two element stores.
// Depends on msb_pkg, msb_ram and msb_merge.
//
//  Channel  | Direction | Handshake                    | Payload
//  ---------+-----------+------------------------------+---------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready | tdata = value, tlast = is_final
//  m_axis   | out       | m_axis_tvalid / m_axis_tready | tdata = sorted_value,
//           |           |                              | tlast = run_end, tuser = overflowed
//
//  Loading takes one request per cycle. Sorting n elements runs ceil(log2 n) merge passes;
//  in each pass the source store's read port fetches one new head per cycle, after a setup
//  and a right-head fetch per run pair. Emitting reads each result through the registered
//  RAM into the result register and loads the next one only after the last is taken.
//  Reset clears all control state at once; the stores need no clearing because only
//  entries written for the current list are ever used.
//  Input is not taken while a list is being sorted or emitted; output stalls hold the
//  result register and the emit pointer.
module merge_sort_buffer_top
    import msb_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic        s_axis_tlast,   // is_final
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] sorted_value
    output logic        m_axis_tlast,   // run_end
    output logic        m_axis_tuser    // [0] overflowed
);

    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int AW = $clog2(MAX_ELEMENTS);

    typedef enum logic [2:0] {
        S_LOAD,
        S_SORT,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_WAIT
    } top_state_t;

    top_state_t    state_reg;
    logic [CW-1:0] count_reg;
    logic          ovf_reg;
    logic          start_reg;
    logic [CW-1:0] emit_idx_reg;
    data_t         out_data_reg;
    logic          out_last_reg;
    logic          out_valid_reg;

    logic          in_fire;
    logic          out_fire;
    logic          has_room;
    logic [CW-1:0] emit_idx_inc;

    logic [AW-1:0] rd_addr;
    data_t         a_rd_data;
    data_t         b_rd_data;
    data_t         src_rd_data;
    logic          a_wr_en;
    logic          b_wr_en;
    logic [AW-1:0] wr_addr;
    data_t         wr_data;

    logic [AW-1:0] merge_rd_addr;
    logic          merge_wr_en;
    logic [AW-1:0] merge_wr_addr;
    data_t         merge_wr_data;
    sort_status_t  sort_status;

    assign s_axis_tready = state_reg == S_LOAD;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign has_room      = count_reg < CW'(MAX_ELEMENTS);
    assign emit_idx_inc  = emit_idx_reg + 1'b1;

    // Both stores share one read address; the source store is picked on the data side
    always_comb
    begin
        unique case (state_reg)
            S_SORT:      rd_addr = merge_rd_addr;
            S_EMIT_RD:   rd_addr = emit_idx_reg[AW-1:0];
            S_EMIT_WAIT: rd_addr = emit_idx_inc[AW-1:0];
            default:     rd_addr = emit_idx_reg[AW-1:0];
        endcase
    end

    assign src_rd_data = sort_status.src_in_b ? b_rd_data : a_rd_data;

    // Loading writes store A; a merge pass writes whichever store is not the source
    assign a_wr_en = (in_fire && has_room) || (merge_wr_en && sort_status.src_in_b);
    assign b_wr_en = merge_wr_en && !sort_status.src_in_b;
    assign wr_addr = (state_reg == S_LOAD) ? count_reg[AW-1:0] : merge_wr_addr;
    assign wr_data = (state_reg == S_LOAD) ? s_axis_tdata : merge_wr_data;

    msb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_store_a (
        .clk     (clk),
        .wr_en   (a_wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (a_rd_data)
    );

    msb_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_store_b (
        .clk     (clk),
        .wr_en   (b_wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (b_rd_data)
    );

    msb_merge #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_reg),
        .count   (count_reg),
        .rd_data (src_rd_data),
        .rd_addr (merge_rd_addr),
        .wr_en   (merge_wr_en),
        .wr_addr (merge_wr_addr),
        .wr_data (merge_wr_data),
        .status  (sort_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            start_reg     <= 1'b0;
            emit_idx_reg  <= '0;
            out_last_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_fire)
                    begin
                        // Store while there is room, otherwise drop and flag it
                        if (has_room)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (s_axis_tlast)
                        begin
                            start_reg <= 1'b1;
                            state_reg <= S_SORT;
                        end
                    end
                end
                S_SORT:
                begin
                    if (sort_status.done)
                    begin
                        emit_idx_reg <= '0;
                        state_reg    <= S_EMIT_RD;
                    end
                end
                S_EMIT_RD:
                begin
                    state_reg <= S_EMIT_LD;
                end
                S_EMIT_LD:
                begin
                    out_data_reg  <= src_rd_data;
                    out_last_reg  <= emit_idx_inc == count_reg;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_EMIT_WAIT;
                end
                S_EMIT_WAIT:
                begin
                    // Hold the result until taken, then fetch the next one
                    if (out_fire)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg)
                        begin
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            emit_idx_reg <= emit_idx_inc;
                            state_reg    <= S_EMIT_LD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = ovf_reg;

endmodule
